[design/knn_pkg.sv]
// Shared types and constants for the nearest-neighbor finder.
`timescale 1ns / 1ps
package knn_pkg;

  localparam int KNN_TABLE_DEPTH   = 128;
  localparam int KNN_MAX_NEIGHBORS = 6;
  localparam int LIMIT_W           = 3;
  localparam int CENTER_W          = 16;
  localparam int DIST_W            = 17;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd6;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rect_x;
    logic [7:0] rect_y;
    logic [7:0] rect_w;
    logic [7:0] rect_h;
    logic [6:0] query_index;
  } in_word_t;

  typedef struct packed {
    logic [6:0]        neighbor_index;
    logic [DIST_W-1:0] distance_sq;
    logic              found;
    logic [1:0]        status;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic       count_clear;
    logic       append;
    logic       query_start;
    logic       qcenter_load;
    logic       pass_init;
    logic       scan_issue;
    logic       take_best;
    logic       out_load;
    logic       out_pend;
    logic [1:0] out_status;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       table_full;
    logic       query_ok;
    logic       scan_last;
    logic       best_have;
    logic       have_pend;
    logic       at_limit;
  } dp_status_t;

endpackage

[design/knn_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/knn_dp.sv]
// Datapath: center table, distance pipeline, best-candidate search and result register.
`timescale 1ns / 1ps
module knn_dp #(
  parameter int MAX_NEIGHBORS = knn_pkg::KNN_MAX_NEIGHBORS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  knn_pkg::in_word_t            in_word,
  input  logic                         cfg_write_en,
  input  logic [knn_pkg::LIMIT_W-1:0]  cfg_write_data,
  input  knn_pkg::ctrl_cmd_t           cmd,
  output knn_pkg::dp_status_t          status,
  output knn_pkg::out_word_t           out_word
);
  import knn_pkg::*;

  localparam int IW = $clog2(KNN_TABLE_DEPTH);
  localparam int CW = $clog2(KNN_TABLE_DEPTH + 1);
  localparam int NW = $clog2(MAX_NEIGHBORS + 1);

  logic [LIMIT_W-1:0]  neighbor_limit;
  logic [CW-1:0]       entry_count;
  logic [IW-1:0]       q_index;
  logic [CENTER_W-1:0] q_center;
  logic [IW-1:0]       scan_index;
  logic                s1_valid;
  logic [IW-1:0]       s1_index;
  logic                s2_valid;
  logic [IW-1:0]       s2_index;
  logic [15:0]         sq_x;
  logic [15:0]         sq_y;
  logic                best_have;
  logic [DIST_W-1:0]   best_dist;
  logic [IW-1:0]       best_index;
  logic                prev_have;
  logic [DIST_W-1:0]   prev_dist;
  logic [IW-1:0]       prev_index;
  logic [DIST_W-1:0]   pend_dist;
  logic [IW-1:0]       pend_index;
  logic [NW-1:0]       nb_count;

  logic [IW-1:0]       ram_addr;
  logic [CENTER_W-1:0] ram_wdata;
  logic [CENTER_W-1:0] ram_rdata;
  logic [7:0]          cx;
  logic [7:0]          cy;
  logic signed [8:0]   dx;
  logic signed [8:0]   dy;
  logic signed [17:0]  prod_x;
  logic signed [17:0]  prod_y;
  logic [DIST_W-1:0]   cand_dist;
  logic                after_prev;
  logic                eligible;
  logic                better;
  logic [NW-1:0]       lim_eff;

  assign cx = in_word.rect_x + {1'b0, in_word.rect_w[7:1]};
  assign cy = in_word.rect_y + {1'b0, in_word.rect_h[7:1]};
  assign ram_wdata = {cy, cx};

  always_comb begin
    if (cmd.append) begin
      ram_addr = entry_count[IW-1:0];
    end else if (cmd.query_start) begin
      ram_addr = in_word.query_index;
    end else begin
      ram_addr = scan_index;
    end
  end

  knn_ram #(
    .WIDTH(CENTER_W),
    .DEPTH(KNN_TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.append),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign dx = $signed({1'b0, ram_rdata[7:0]}) - $signed({1'b0, q_center[7:0]});
  assign dy = $signed({1'b0, ram_rdata[15:8]}) - $signed({1'b0, q_center[15:8]});
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign cand_dist = {1'b0, sq_x} + {1'b0, sq_y};

  assign after_prev = !prev_have || (cand_dist > prev_dist) ||
                      ((cand_dist == prev_dist) && (s2_index > prev_index));
  assign eligible = s2_valid && (s2_index != q_index) && after_prev;
  assign better = !best_have || (cand_dist < best_dist);

  always_comb begin
    if (neighbor_limit == '0) begin
      lim_eff = NW'(1);
    end else if (int'(neighbor_limit) > MAX_NEIGHBORS) begin
      lim_eff = NW'(MAX_NEIGHBORS);
    end else begin
      lim_eff = NW'(neighbor_limit);
    end
  end

  always_comb begin
    status.func       = in_word.func;
    status.table_full = (entry_count == CW'(KNN_TABLE_DEPTH));
    status.query_ok   = (CW'(in_word.query_index) < entry_count);
    status.scan_last  = ((CW'(scan_index) + CW'(1)) == entry_count);
    status.best_have  = best_have;
    status.have_pend  = (nb_count != '0);
    status.at_limit   = (NW'(nb_count + NW'(1)) == lim_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_limit <= LIMIT_RESET;
      entry_count    <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      best_have      <= 1'b0;
      prev_have      <= 1'b0;
      nb_count       <= '0;
      scan_index     <= '0;
    end else begin
      if (cfg_write_en) begin
        neighbor_limit <= cfg_write_data;
      end
      if (cmd.count_clear) begin
        entry_count <= '0;
      end else if (cmd.append) begin
        entry_count <= entry_count + CW'(1);
      end
      if (cmd.query_start) begin
        prev_have <= 1'b0;
        nb_count  <= '0;
      end else if (cmd.take_best) begin
        prev_have <= 1'b1;
        nb_count  <= nb_count + NW'(1);
      end
      s1_valid <= cmd.scan_issue;
      s2_valid <= s1_valid;
      if (cmd.pass_init) begin
        scan_index <= '0;
        best_have  <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_index <= scan_index + IW'(1);
        end
        if (eligible && better) begin
          best_have <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_index <= in_word.query_index;
    end
    if (cmd.qcenter_load) begin
      q_center <= ram_rdata;
    end
    s1_index <= scan_index;
    s2_index <= s1_index;
    sq_x     <= prod_x[15:0];
    sq_y     <= prod_y[15:0];
    if (!cmd.pass_init && eligible && better) begin
      best_dist  <= cand_dist;
      best_index <= s2_index;
    end
    if (cmd.take_best) begin
      prev_dist  <= best_dist;
      prev_index <= best_index;
      pend_dist  <= best_dist;
      pend_index <= best_index;
    end
    if (cmd.out_load) begin
      if (cmd.out_pend) begin
        out_word.neighbor_index <= pend_index;
        out_word.distance_sq    <= pend_dist;
        out_word.found          <= 1'b1;
        out_word.status         <= STATUS_OK;
      end else begin
        out_word.neighbor_index <= '0;
        out_word.distance_sq    <= '0;
        out_word.found          <= 1'b0;
        out_word.status         <= cmd.out_status;
      end
      out_word.last <= cmd.out_last;
    end
  end

endmodule

[design/knn_ctrl.sv]
// Controller: sequences table updates, search passes and result hand-off.
`timescale 1ns / 1ps
module knn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  knn_pkg::dp_status_t status,
  output knn_pkg::ctrl_cmd_t  cmd
);
  import knn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QLOAD,
    S_SCAN,
    S_DRAIN1,
    S_DRAIN2,
    S_DECIDE,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   in_take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          case (status.func)
            FUNC_CLEAR: begin
              cmd.count_clear = 1'b1;
              cmd.out_load    = 1'b1;
              cmd.out_last    = 1'b1;
            end
            FUNC_APPEND: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (status.table_full) begin
                cmd.out_status = STATUS_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (status.query_ok) begin
                cmd.query_start = 1'b1;
                state_next      = S_QLOAD;
              end else begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STATUS_BAD_INDEX;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
          endcase
        end
      end
      S_QLOAD: begin
        cmd.qcenter_load = 1'b1;
        cmd.pass_init    = 1'b1;
        state_next       = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN1;
        end
      end
      S_DRAIN1: begin
        state_next = S_DRAIN2;
      end
      S_DRAIN2: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.best_have) begin
          if (!status.have_pend || out_free) begin
            cmd.take_best = 1'b1;
            cmd.out_load  = status.have_pend;
            cmd.out_pend  = 1'b1;
            if (status.at_limit) begin
              state_next = S_FLUSH;
            end else begin
              cmd.pass_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
        end else if (status.have_pend) begin
          state_next = S_FLUSH;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pend = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/knn_point_neighbor_finder.sv]
// Top level of the nearest-neighbor finder over a table of rectangle centers.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_stall, in_word           | in
//   output  | out_valid, out_stall, out_word        | out
//   config  | cfg_write_en, cfg_write_data          | in
//
// Clear, append and rejected queries yield one word each.
// A query makes search passes up to the neighbor limit; each pass reads the center RAM
// once per stored entry.
// Reset is synchronous; the table contents are not cleared, only the entry count.
// Output stall holds the result register and, in turn, the search and the input.
`timescale 1ns / 1ps
module knn_point_neighbor_finder #(
  parameter int MAX_NEIGHBORS = knn_pkg::KNN_MAX_NEIGHBORS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  knn_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output knn_pkg::out_word_t          out_word,
  input  logic                        cfg_write_en,
  input  logic [knn_pkg::LIMIT_W-1:0] cfg_write_data
);
  import knn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  knn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  knn_dp #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_word       (in_word),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .cmd           (cmd),
    .status        (status),
    .out_word      (out_word)
  );

`ifndef SYNTHESIS
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.found) |-> (out_word.status == STATUS_OK))
    else $error("neighbor word carries a nonzero status");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.found) |->
      (out_word.neighbor_index == '0 && out_word.distance_sq == '0))
    else $error("empty word carries index or distance");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.found) |-> out_word.last)
    else $error("empty word not marked last");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && out_valid) |-> !out_stall)
    else $error("result register overwritten while stalled");
`endif

endmodule

[verif/tb_knn_point_neighbor_finder.sv]
// Testbench for the nearest-neighbor finder: directed and random words checked by a predictor.
`timescale 1ns / 1ps
module tb_knn_point_neighbor_finder;
  import knn_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         LONG_HOLD     = 400;
  localparam int         TIMEOUT_NS    = 3_000_000;
  localparam int         ITEM_TARGET   = 310;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  in_word_t            in_word        = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  out_word_t           out_word;
  logic                cfg_write_en   = 1'b0;
  logic [LIMIT_W-1:0]  cfg_write_data = '0;

  knn_point_neighbor_finder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus side
  in_word_t pending_words[$];
  int       items_queued  = 0;
  int       plan_count    = 0;
  int       gap_pct       = 0;
  int       stall_pct     = 0;
  int       hold_requests = 0;
  int       limit_writes  = 0;

  // predictor side
  logic [7:0]         cx_mem [KNN_TABLE_DEPTH];
  logic [7:0]         cy_mem [KNN_TABLE_DEPTH];
  int                 stored_count  = 0;
  logic [LIMIT_W-1:0] limit_shadow  = LIMIT_RESET;
  out_word_t          expected_words[$];
  int                 items_taken   = 0;
  int                 words_checked = 0;
  int                 neighbor_words = 0;
  int                 queries_taken = 0;
  int                 full_drops    = 0;
  int                 mismatches    = 0;
  logic               in_acc        = 1'b0;

  function automatic void push_word(input logic [6:0] idx, input logic [DIST_W-1:0] dist_v,
                                    input logic fnd, input logic [1:0] st, input logic lst);
    out_word_t w;
    w.neighbor_index = idx;
    w.distance_sq    = dist_v;
    w.found          = fnd;
    w.status         = st;
    w.last           = lst;
    expected_words.push_back(w);
  endfunction

  task automatic predict_words(input in_word_t w);
    int   lim, n, best, best_d, d, dx, dy, q;
    bit   have;
    bit   picked [KNN_TABLE_DEPTH];
    int   hit_idx [KNN_MAX_NEIGHBORS];
    int   hit_dist [KNN_MAX_NEIGHBORS];
    case (w.func)
      FUNC_CLEAR: begin
        stored_count = 0;
        push_word('0, '0, 1'b0, STATUS_OK, 1'b1);
      end
      FUNC_APPEND: begin
        if (stored_count >= KNN_TABLE_DEPTH) begin
          full_drops++;
          push_word('0, '0, 1'b0, STATUS_FULL, 1'b1);
        end else begin
          cx_mem[stored_count] = w.rect_x + (w.rect_w >> 1);
          cy_mem[stored_count] = w.rect_y + (w.rect_h >> 1);
          stored_count++;
          push_word('0, '0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      FUNC_QUERY: begin
        queries_taken++;
        q = w.query_index;
        if (q >= stored_count) begin
          push_word('0, '0, 1'b0, STATUS_BAD_INDEX, 1'b1);
        end else begin
          lim = limit_shadow;
          if (lim < 1) lim = 1;
          if (lim > KNN_MAX_NEIGHBORS) lim = KNN_MAX_NEIGHBORS;
          foreach (picked[i]) picked[i] = 1'b0;
          n = 0;
          for (int pass = 0; pass < lim; pass++) begin
            have   = 1'b0;
            best   = 0;
            best_d = 0;
            for (int j = 0; j < stored_count; j++) begin
              if (j == q || picked[j]) continue;
              dx = int'(cx_mem[q]) - int'(cx_mem[j]);
              dy = int'(cy_mem[q]) - int'(cy_mem[j]);
              d  = dx * dx + dy * dy;
              if (!have || d < best_d) begin
                have   = 1'b1;
                best   = j;
                best_d = d;
              end
            end
            if (!have) break;
            picked[best] = 1'b1;
            hit_idx[n]   = best;
            hit_dist[n]  = best_d;
            n++;
          end
          if (n == 0) begin
            push_word('0, '0, 1'b0, STATUS_OK, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              push_word(7'(hit_idx[i]), DIST_W'(hit_dist[i]), 1'b1, STATUS_OK, i == n - 1);
            end
          end
        end
      end
      default: push_word('0, '0, 1'b0, STATUS_OK, 1'b1);
    endcase
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t unexpected word: idx %0d dist %0d found %0d status %0d last %0d",
                 $realtime, got.neighbor_index, got.distance_sq, got.found, got.status,
                 got.last);
      end
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      if (got.found) neighbor_words++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t mismatch: want idx %0d dist %0d found %0d status %0d last %0d",
                   $realtime, want.neighbor_index, want.distance_sq, want.found,
                   want.status, want.last);
          $display("%0t           got  idx %0d dist %0d found %0d status %0d last %0d",
                   $realtime, got.neighbor_index, got.distance_sq, got.found,
                   got.status, got.last);
        end
      end
    end
  endtask

  // sample at the rising edge
  always @(posedge clk) begin
    in_acc <= in_valid && !in_stall;
    if (!rst) begin
      if (cfg_write_en) limit_shadow = cfg_write_data;
      if (in_valid && !in_stall) begin
        predict_words(in_word);
        items_taken++;
      end
      if (out_valid && !out_stall) check_word(out_word);
    end
  end

  // input driver
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver
  int stall_left   = 0;
  int long_left    = 0;
  int holds_served = 0;
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      long_left    = LONG_HOLD;
    end
    if (long_left > 0) begin
      long_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] pick_coord();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 4) * 16);
  endfunction

  function automatic void queue_word(input logic [1:0] f, input logic [7:0] x,
                                     input logic [7:0] y, input logic [7:0] w,
                                     input logic [7:0] h, input logic [6:0] q);
    in_word_t iw;
    iw.func        = f;
    iw.rect_x      = x;
    iw.rect_y      = y;
    iw.rect_w      = w;
    iw.rect_h      = h;
    iw.query_index = q;
    pending_words.push_back(iw);
    items_queued++;
  endfunction

  function automatic void add_rect(input logic [7:0] x, input logic [7:0] y,
                                   input logic [7:0] w, input logic [7:0] h);
    queue_word(FUNC_APPEND, x, y, w, h, 7'($urandom_range(0, 127)));
    if (plan_count < KNN_TABLE_DEPTH) plan_count++;
  endfunction

  function automatic void add_random_rect();
    add_rect(pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endfunction

  function automatic void ask(input logic [6:0] q);
    queue_word(FUNC_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), q);
  endfunction

  function automatic void ask_stored();
    if (plan_count > 0) ask(7'($urandom_range(0, plan_count - 1)));
    else ask(7'($urandom_range(0, 127)));
  endfunction

  function automatic void add_op(input logic [1:0] f);
    queue_word(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               7'($urandom_range(0, 127)));
    if (f == FUNC_CLEAR) plan_count = 0;
  endfunction

  task automatic settle();
    while (items_taken != items_queued || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_write_data <= v;
    cfg_write_en   <= 1'b1;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    limit_writes++;
  endtask

  function automatic void pick_pacing();
    case ($urandom_range(0, 3))
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 10; stall_pct = 10; end
      2: begin gap_pct = 30; stall_pct = 5;  end
      default: begin gap_pct = 5; stall_pct = 30; end
    endcase
  endfunction

  // a mostly well-formed burst: clear, appends and queries, with some noise
  function automatic void small_phase();
    int m, r;
    if ($urandom_range(0, 4) != 0) add_op(FUNC_CLEAR);
    add_random_rect();
    m = $urandom_range(8, 22);
    for (int i = 0; i < m; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) add_random_rect();
      else if (r < 85) ask_stored();
      else if (r < 92) ask(7'($urandom_range(0, 127)));
      else if (r < 96) add_op(FUNC_UNUSED);
      else add_op(FUNC_CLEAR);
    end
  endfunction

  logic [LIMIT_W-1:0] limit_plan [8] = '{3'd1, 3'd0, 3'd7, 3'd6, 3'd3, 3'd2, 3'd5, 3'd4};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pick_pacing();

    ask(7'd0);
    add_op(FUNC_UNUSED);
    add_rect(8'd0, 8'd0, 8'd0, 8'd0);
    ask(7'd0);
    add_rect(8'd255, 8'd255, 8'd255, 8'd255);
    add_rect(8'd250, 8'd10, 8'd12, 8'd0);
    add_rect(8'd0, 8'd0, 8'd20, 8'd0);
    add_rect(8'd255, 8'd0, 8'd1, 8'd255);
    add_rect(8'd0, 8'd0, 8'd0, 8'd0);
    add_rect(8'd200, 8'd200, 8'd110, 8'd110);
    ask(7'd0);
    ask(7'd6);
    ask(7'd7);
    ask(7'd127);
    add_op(FUNC_CLEAR);
    ask(7'd0);
    add_rect(8'd1, 8'd2, 8'd3, 8'd4);
    add_rect(8'd1, 8'd2, 8'd3, 8'd4);
    ask(7'd1);
    add_op(FUNC_UNUSED);
    ask(7'd0);
    settle();

    // fill the table to the brim, then query it
    write_limit(3'd7);
    pick_pacing();
    add_op(FUNC_CLEAR);
    for (int i = 0; i < KNN_TABLE_DEPTH + 2; i++) add_random_rect();
    ask(7'd0);
    ask(7'd127);
    for (int i = 0; i < 4; i++) ask_stored();
    settle();

    // long output hold while the sender keeps offering
    write_limit(3'd6);
    gap_pct   = 0;
    stall_pct = 0;
    add_op(FUNC_CLEAR);
    for (int i = 0; i < 12; i++) add_random_rect();
    hold_requests++;
    for (int i = 0; i < 24; i++) ask_stored();
    settle();

    for (int p = 0; items_queued < ITEM_TARGET - 40; p++) begin
      write_limit(p < 8 ? limit_plan[p] : LIMIT_W'($urandom_range(0, 7)));
      pick_pacing();
      small_phase();
      settle();
    end

    // quiet tail
    write_limit(LIMIT_W'($urandom_range(1, 6)));
    gap_pct   = 0;
    stall_pct = 0;
    while (items_queued < ITEM_TARGET) small_phase();
    settle();

    $display("Run covered %0d input words (%0d queries, %0d full-table drops) over %0d limit writes",
             items_taken, queries_taken, full_drops, limit_writes);
    $display("and %0d result words (%0d neighbors); %0d mismatches",
             words_checked, neighbor_words, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/knn_pkg.sv
design/knn_ram.sv
design/knn_dp.sv
design/knn_ctrl.sv
design/knn_point_neighbor_finder.sv
verif/tb_knn_point_neighbor_finder.sv
